@@ hw/rtl/hqi_pkg.sv @@
// Package for the histogram quantile interpolator: constants, types, enums.
package hqi_pkg;

	localparam int QUANTILE_COUNT = 5;
	localparam int EDGE_BITS      = 32;

	localparam int REG_COUNT = 5;
	localparam int CFG_IDX_W = 3;
	localparam int THR_W     = 16;
	localparam int WEIGHT_W  = 16;
	localparam int EDGE_IN_W = 32;
	localparam int OUT_IDX_W = 3;
	localparam int SUM_W     = 20;

	localparam int EDGE_W     = (EDGE_BITS > 32) ? 32 : ((EDGE_BITS < 2) ? 2 : EDGE_BITS);
	localparam int QW         = $clog2(QUANTILE_COUNT + 1);
	localparam int THR_IDX_W  = $clog2(REG_COUNT);
	localparam int NUM_W      = SUM_W + 1;
	localparam int DIFF_W     = EDGE_W + 1;
	localparam int PROD_W     = NUM_W + DIFF_W;
	localparam int AW         = PROD_W + 1;
	localparam int CNT_W      = $clog2(PROD_W);

	localparam logic [THR_W-1:0] THR_SPARE = '1;
	localparam logic [THR_W-1:0] THR_RESET [REG_COUNT] = '{
		16'd1494, 16'd10401, 16'd32768, 16'd55135, 16'd64042
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PEEK,
		ST_CALC,
		ST_EMIT
	} hqi_state_t;

	typedef enum logic [2:0] {
		U_IDLE,
		U_MUL,
		U_DIV,
		U_NEG,
		U_BASE,
		U_DONE
	} hqi_ust_t;

	typedef struct packed {
		logic                     start;
		logic signed [NUM_W-1:0]  num;
		logic signed [DIFF_W-1:0] diff;
		logic [SUM_W-1:0]         den;
		logic signed [EDGE_W-1:0] base;
	} hqi_mdreq_t;

	typedef struct packed {
		logic                     done;
		logic signed [EDGE_W-1:0] value;
	} hqi_mdrsp_t;

endpackage

@@ hw/rtl/hqi_thr_regs.sv @@
// Threshold register file with one read port.
module hqi_thr_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic [hqi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hqi_pkg::THR_W-1:0]     cfg_data,
	input  logic [hqi_pkg::QW-1:0]        rd_idx,
	output logic [hqi_pkg::THR_W-1:0]     thr_rd
);
	import hqi_pkg::*;

	localparam int RX_W = (QW > THR_IDX_W) ? QW : THR_IDX_W;

	logic [THR_W-1:0] thr_q [REG_COUNT];
	logic [RX_W-1:0]  idx_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				thr_q[i] <= THR_RESET[i];
			end
		end else if (cfg_valid && (cfg_index < CFG_IDX_W'(REG_COUNT))) begin
			thr_q[cfg_index[THR_IDX_W-1:0]] <= cfg_data;
		end
	end

	// slots past the register list read as full scale
	assign idx_x  = RX_W'(rd_idx);
	assign thr_rd = (idx_x < RX_W'(REG_COUNT)) ? thr_q[idx_x[THR_IDX_W-1:0]] : THR_SPARE;

endmodule

@@ hw/rtl/hqi_muldiv.sv @@
// Iterative multiply, floor divide and offset unit around one shared adder.
module hqi_muldiv (
	input  logic                clk,
	input  logic                arst_n,
	input  hqi_pkg::hqi_mdreq_t req,
	output hqi_pkg::hqi_mdrsp_t rsp
);
	import hqi_pkg::*;

	localparam logic signed [AW-1:0] V_HI = AW'((64'sd1 <<< (EDGE_W - 1)) - 64'sd1);
	localparam logic signed [AW-1:0] V_LO = ~V_HI;

	hqi_ust_t st_q, st_d;

	logic [AW-1:0]     acc_q;
	logic [AW-1:0]     mcand_q;
	logic [NUM_W-1:0]  mul_a_q;
	logic [SUM_W-1:0]  rem_q;
	logic [SUM_W-1:0]  den_q;
	logic signed [EDGE_W-1:0] base_q;
	logic              neg_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [AW-1:0]     add_a, add_b, add_sum;
	logic              add_cin;
	logic [NUM_W-1:0]  num_mag;
	logic [DIFF_W-1:0] diff_mag;
	logic signed [AW-1:0] acc_s;

	assign num_mag  = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
	assign diff_mag = req.diff[DIFF_W-1] ? DIFF_W'(-req.diff) : DIFF_W'(req.diff);
	assign add_sum  = add_a + add_b + AW'(add_cin);
	assign acc_s    = $signed(acc_q);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			U_IDLE: if (req.start) st_d = U_MUL;
			U_MUL:  if (cnt_q == CNT_W'(NUM_W - 1)) st_d = U_DIV;
			U_DIV: begin
				if (cnt_q == CNT_W'(PROD_W - 1)) st_d = neg_q ? U_NEG : U_BASE;
			end
			U_NEG:  st_d = U_BASE;
			U_BASE: st_d = U_DONE;
			U_DONE: st_d = U_IDLE;
			default: st_d = U_IDLE;
		endcase
	end

	// adder operands and response
	always_comb begin
		add_a     = '0;
		add_b     = '0;
		add_cin   = 1'b0;
		rsp.done  = 1'b0;
		rsp.value = acc_s[EDGE_W-1:0];
		if (acc_s > V_HI) begin
			rsp.value = EDGE_W'(V_HI);
		end else if (acc_s < V_LO) begin
			rsp.value = EDGE_W'(V_LO);
		end
		unique case (st_q)
			U_MUL: begin
				add_a = acc_q;
				add_b = mcand_q;
			end
			U_DIV: begin
				add_a   = AW'({rem_q, acc_q[PROD_W-1]});
				add_b   = ~AW'(den_q);
				add_cin = 1'b1;
			end
			U_NEG: begin
				// -(q + r!=0) = ~q + (r==0)
				add_a   = ~acc_q;
				add_cin = (rem_q == '0);
			end
			U_BASE: begin
				add_a = acc_q;
				add_b = AW'(base_q);
			end
			U_DONE: rsp.done = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= U_IDLE;
			cnt_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q != st_d) begin
				cnt_q <= '0;
			end else if (st_q == U_MUL || st_q == U_DIV) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			U_IDLE: begin
				if (req.start) begin
					acc_q   <= '0;
					mcand_q <= AW'(diff_mag);
					mul_a_q <= num_mag;
					rem_q   <= '0;
					den_q   <= req.den;
					base_q  <= req.base;
					neg_q   <= req.num[NUM_W-1] ^ req.diff[DIFF_W-1];
				end
			end
			U_MUL: begin
				if (mul_a_q[0]) acc_q <= add_sum;
				mcand_q <= mcand_q << 1;
				mul_a_q <= mul_a_q >> 1;
			end
			U_DIV: begin
				// restoring step: quotient bits shift in as product bits shift out
				if (!add_sum[AW-1]) begin
					rem_q <= add_sum[SUM_W-1:0];
					acc_q <= {1'b0, acc_q[PROD_W-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[SUM_W-2:0], acc_q[PROD_W-1]};
					acc_q <= {1'b0, acc_q[PROD_W-2:0], 1'b0};
				end
			end
			U_NEG:  acc_q <= add_sum;
			U_BASE: acc_q <= add_sum;
			default: ;
		endcase
	end

endmodule

@@ hw/rtl/histogram_quantile_interpolator_top.sv @@
// Top level of the histogram quantile interpolator: sequencer, running state, ports.
// Bins are taken one request at a time: in_ready stays low until the current bin is done.
// A quantile taken as the bin edge passes the scan and peek states before it is offered.
// An interpolated quantile also waits in the calc state: 21 multiply steps, 54 divide steps,
// plus a negate step for a negative quotient, then offset and hand-off, all on one 55-bit adder.
// Reset: thresholds take their defaults, sums, previous edge and quantile index clear.
module histogram_quantile_interpolator_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [hqi_pkg::WEIGHT_W-1:0]         bin_weight,
	input  logic signed [hqi_pkg::EDGE_IN_W-1:0] bin_edge,
	input  logic                                first_bin,
	input  logic                                last_bin,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [hqi_pkg::OUT_IDX_W-1:0]        quantile_index,
	output logic signed [hqi_pkg::EDGE_IN_W-1:0] quantile_value,
	output logic                                reached,
	output logic                                last_of_run,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [hqi_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [hqi_pkg::THR_W-1:0]            cfg_data
);
	import hqi_pkg::*;

	hqi_state_t state_q, state_d;

	// running histogram state
	logic [SUM_W-1:0]         rs_q;
	logic [SUM_W-1:0]         ps_q;
	logic signed [EDGE_W-1:0] pe_q;
	logic [QW-1:0]            nq_q;

	// current bin request
	logic signed [EDGE_W-1:0] edge_q;
	logic                     wnz_q;
	logic                     last_q;
	logic                     xdone_q;   // crossing phase over, only flushing remains
	logic                     use_unit_q;

	// output register
	logic [OUT_IDX_W-1:0]     out_idx_q;
	logic signed [EDGE_W-1:0] out_val_q;
	logic                     out_hit_q;
	logic                     out_last_q;

	logic [THR_W-1:0]         thr_rd;
	logic [SUM_W:0]           sum_c;
	logic [SUM_W-1:0]         rs_base;
	logic [SUM_W-1:0]         den_c;
	logic                     nq_lt_n;
	logic                     above_c;
	logic                     cross_c;
	logic                     flush_c;
	logic                     direct_c;
	logic                     md_start;

	hqi_mdreq_t md_req;
	hqi_mdrsp_t md_rsp;

	hqi_thr_regs u_thr (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rd_idx    (nq_q),
		.thr_rd    (thr_rd)
	);

	hqi_muldiv u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	// saturating accumulate; a first mark restarts from zero
	assign rs_base = first_bin ? '0 : rs_q;
	assign sum_c   = (SUM_W + 1)'(rs_base) + (SUM_W + 1)'(bin_weight);

	// the threshold port always reads the pending quantile
	assign nq_lt_n  = (nq_q < QW'(QUANTILE_COUNT));
	assign above_c  = (rs_q > SUM_W'(thr_rd));
	assign cross_c  = nq_lt_n && wnz_q && !xdone_q && above_c;
	assign flush_c  = nq_lt_n && last_q;
	assign den_c    = rs_q - ps_q;
	assign direct_c = (ps_q == '0) || (den_c == '0);

	assign md_req.start = md_start;
	assign md_req.num   = NUM_W'(thr_rd) - NUM_W'(ps_q);
	assign md_req.diff  = DIFF_W'(edge_q) - DIFF_W'(pe_q);
	assign md_req.den   = den_c;
	assign md_req.base  = pe_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_SCAN;
			ST_SCAN: begin
				priority if (cross_c) state_d = ST_PEEK;
				else if (flush_c)     state_d = ST_EMIT;
				else                  state_d = ST_IDLE;
			end
			ST_PEEK: state_d = use_unit_q ? ST_CALC : ST_EMIT;
			ST_CALC: if (md_rsp.done) state_d = ST_EMIT;
			ST_EMIT: if (out_ready) state_d = ST_SCAN;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		out_valid = (state_q == ST_EMIT);
		md_start  = (state_q == ST_SCAN) && cross_c && !direct_c;
	end

	assign cfg_ready      = 1'b1;
	assign quantile_index = out_idx_q;
	assign quantile_value = EDGE_IN_W'(out_val_q);
	assign reached        = out_hit_q;
	assign last_of_run    = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rs_q    <= '0;
			ps_q    <= '0;
			pe_q    <= '0;
			nq_q    <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (first_bin) begin
							ps_q <= '0;
							pe_q <= '0;
							nq_q <= '0;
						end
						if (bin_weight != '0) begin
							rs_q <= sum_c[SUM_W] ? '1 : sum_c[SUM_W-1:0];
						end else begin
							rs_q <= rs_base;
						end
					end
				end
				ST_SCAN: begin
					if (cross_c || flush_c) begin
						nq_q <= nq_q + QW'(1);
					end else if (wnz_q) begin
						// request finished: this bin becomes the previous one
						ps_q <= rs_q;
						pe_q <= edge_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					edge_q  <= bin_edge[EDGE_W-1:0];
					wnz_q   <= (bin_weight != '0);
					last_q  <= last_bin;
					xdone_q <= 1'b0;
				end
			end
			ST_SCAN: begin
				priority if (cross_c) begin
					out_idx_q  <= OUT_IDX_W'(nq_q);
					out_hit_q  <= 1'b1;
					out_val_q  <= edge_q;
					use_unit_q <= !direct_c;
				end else if (flush_c) begin
					out_idx_q  <= OUT_IDX_W'(nq_q);
					out_hit_q  <= 1'b0;
					out_val_q  <= '0;
					out_last_q <= (nq_q == QW'(QUANTILE_COUNT - 1));
					xdone_q    <= 1'b1;
				end else begin
					xdone_q <= 1'b1;
				end
			end
			ST_PEEK: begin
				// nq_q already points past the crossing just taken
				out_last_q <= !(nq_lt_n && (last_q || above_c));
			end
			ST_CALC: begin
				if (md_rsp.done) out_val_q <= md_rsp.value;
			end
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output offered together");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((OUT_IDX_W + 1)'(quantile_index) < (OUT_IDX_W + 1)'(QUANTILE_COUNT)))
		else $error("quantile index out of range");

	a_unreached_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !reached) |-> (quantile_value == '0))
		else $error("unreached quantile carries a value");

	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		md_rsp.done |-> (state_q == ST_CALC))
		else $error("muldiv finished outside of calc");

	a_idx_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> (QW'(nq_q) == $past(nq_q)))
		else $error("quantile index moved during hand-off");
`endif

endmodule
